// ===== rtl/trd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package trd_pkg;

  localparam int MAX_PIXEL_BYTES = 3;

  localparam int PIX_W  = 24;
  localparam int LEFT_W = 8;
  localparam int IMG_W  = 32;
  localparam int PB_W   = 2;

  localparam int HDR_RUN_BIT = 7;
  localparam logic [6:0] HDR_COUNT_MASK = 7'h7F;

  localparam logic REG_PIXEL_BYTES  = 1'b0;
  localparam logic REG_IMAGE_PIXELS = 1'b1;

  localparam logic [PB_W-1:0]  PIXEL_BYTES_RST  = PB_W'(3);
  localparam logic [IMG_W-1:0] IMAGE_PIXELS_RST = IMG_W'(1);

  typedef enum logic {
    S_IN,
    S_RUN
  } ctrl_state_t;

  typedef struct packed {
    logic take;
    logic emit;
  } trd_cmd_t;

  typedef struct packed {
    logic out_free;
    logic run_more;
    logic emit_final;
  } trd_status_t;

  function automatic logic [PB_W-1:0] eff_pixel_bytes(input logic [PB_W-1:0] pb);
    logic [PB_W-1:0] r;
    r = pb;
    if (r == '0) r = PB_W'(1);
    if (r > PB_W'(MAX_PIXEL_BYTES)) r = PB_W'(MAX_PIXEL_BYTES);
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tga_rle_decoder.sv =====
// a pixel's result is registered and shown in the cycle after its last byte is taken
// headers and inner pixel bytes give no result; one byte per cycle otherwise, when not stalled
// a run of n pixels fills ceil(n/2) results in the output register,
// and input stalls while the run expander drains, plus any output back-pressure
// reset (synchronous): header expected, counts clear, pixel_bytes 3, image_pixels 1
`timescale 1ns / 1ps
`default_nettype none

module tga_rle_decoder (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [7:0]                data_byte,
  input  wire logic                      frame_start,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic                      cfg_index,
  input  wire logic [trd_pkg::IMG_W-1:0] cfg_data,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [trd_pkg::PIX_W-1:0]      pixel_first,
  output logic [trd_pkg::PIX_W-1:0]      pixel_second,
  output logic [1:0]                     pixel_count,
  output logic                           last_of_packet,
  output logic                           last_of_image
);
  import trd_pkg::*;

  trd_cmd_t    cmd;
  trd_status_t status;

  assign cfg_ready = 1'b1;

  trd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  trd_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .data_byte      (data_byte),
    .frame_start    (frame_start),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .pixel_first    (pixel_first),
    .pixel_second   (pixel_second),
    .pixel_count    (pixel_count),
    .last_of_packet (last_of_packet),
    .last_of_image  (last_of_image)
  );

endmodule

`default_nettype wire

// ===== rtl/trd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module trd_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire trd_pkg::trd_status_t status,
  output trd_pkg::trd_cmd_t         cmd
);
  import trd_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IN: begin
        if (cmd.take && status.run_more) state_next = S_RUN;
      end
      S_RUN: begin
        if (cmd.emit && status.emit_final) state_next = S_IN;
      end
      default: state_next = S_IN;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      S_IN: begin
        in_ready = status.out_free;
        cmd.take = in_valid && status.out_free;
      end
      S_RUN: begin
        cmd.emit = status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/trd_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module trd_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [7:0]                  data_byte,
  input  wire logic                        frame_start,
  input  wire logic                        cfg_valid,
  input  wire logic                        cfg_index,
  input  wire logic [trd_pkg::IMG_W-1:0]   cfg_data,
  input  wire trd_pkg::trd_cmd_t           cmd,
  output trd_pkg::trd_status_t             status,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [trd_pkg::PIX_W-1:0]        pixel_first,
  output logic [trd_pkg::PIX_W-1:0]        pixel_second,
  output logic [1:0]                       pixel_count,
  output logic                             last_of_packet,
  output logic                             last_of_image
);
  import trd_pkg::*;

  // configuration
  logic [PB_W-1:0]  pixel_bytes;
  logic [IMG_W-1:0] image_pixels;

  // decoder state
  logic              expecting_header;
  logic              packet_is_run;
  logic [LEFT_W-1:0] pixels_left;
  logic [1:0]        byte_position;
  logic [PIX_W-1:0]  pixel_assembly;
  logic [IMG_W-1:0]  pixels_done;
  logic              image_finished;

  // run expansion
  logic [PIX_W-1:0]  run_pix;
  logic [LEFT_W-1:0] emit_left;
  logic              run_fin;

  // effective state after an optional frame start
  logic              e_hdr, e_run, e_fin;
  logic [LEFT_W-1:0] e_left;
  logic [1:0]        e_bp;
  logic [PIX_W-1:0]  e_asm;
  logic [IMG_W-1:0]  e_done;

  logic              done_now, complete, produce;
  logic [IMG_W-1:0]  asm_ext;
  logic [PIX_W-1:0]  asm_new;
  logic [IMG_W-1:0]  remaining;
  logic [LEFT_W-1:0] n, first_cnt, first_left, left_dec;
  logic              fin_new;
  logic [LEFT_W-1:0] step_cnt, step_left;

  always_comb begin
    e_hdr  = frame_start | expecting_header;
    e_run  = frame_start ? 1'b0 : packet_is_run;
    e_left = frame_start ? '0 : pixels_left;
    e_bp   = frame_start ? '0 : byte_position;
    e_asm  = frame_start ? '0 : pixel_assembly;
    e_done = frame_start ? '0 : pixels_done;
    e_fin  = frame_start ? 1'b0 : image_finished;

    done_now  = e_fin || (e_done >= image_pixels);
    asm_ext   = {{(IMG_W-PIX_W){1'b0}}, e_asm}
              | ({{(IMG_W-8){1'b0}}, data_byte} << {e_bp, 3'b000});
    asm_new   = asm_ext[PIX_W-1:0];
    complete  = ({1'b0, e_bp} + 3'd1) >= {1'b0, eff_pixel_bytes(pixel_bytes)};
    remaining = image_pixels - e_done;
    left_dec  = e_left - LEFT_W'(1);

    if (e_run) begin
      n = ({{(IMG_W-LEFT_W){1'b0}}, e_left} > remaining) ? remaining[LEFT_W-1:0] : e_left;
    end else begin
      n = LEFT_W'(1);
    end
    fin_new    = ({{(IMG_W-LEFT_W){1'b0}}, n} == remaining);
    first_cnt  = (n >= LEFT_W'(2)) ? LEFT_W'(2) : LEFT_W'(1);
    first_left = n - first_cnt;
    produce    = !done_now && !e_hdr && complete;

    step_cnt  = (emit_left >= LEFT_W'(2)) ? LEFT_W'(2) : LEFT_W'(1);
    step_left = emit_left - step_cnt;

    status.out_free   = !out_valid || out_ready;
    status.run_more   = produce && (first_left != '0);
    status.emit_final = (emit_left <= LEFT_W'(2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_bytes  <= PIXEL_BYTES_RST;
      image_pixels <= IMAGE_PIXELS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PIXEL_BYTES:  pixel_bytes  <= cfg_data[PB_W-1:0];
        REG_IMAGE_PIXELS: image_pixels <= cfg_data;
        default:          pixel_bytes  <= pixel_bytes;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expecting_header <= 1'b1;
      packet_is_run    <= 1'b0;
      pixels_left      <= '0;
      byte_position    <= '0;
      pixel_assembly   <= '0;
      pixels_done      <= '0;
      image_finished   <= 1'b0;
    end else if (cmd.take) begin
      if (done_now) begin
        expecting_header <= e_hdr;
        packet_is_run    <= e_run;
        pixels_left      <= e_left;
        byte_position    <= e_bp;
        pixel_assembly   <= e_asm;
        pixels_done      <= e_done;
        image_finished   <= 1'b1;
      end else if (e_hdr) begin
        packet_is_run    <= data_byte[HDR_RUN_BIT];
        pixels_left      <= {1'b0, data_byte[6:0] & HDR_COUNT_MASK} + LEFT_W'(1);
        byte_position    <= '0;
        pixel_assembly   <= '0;
        expecting_header <= 1'b0;
        pixels_done      <= e_done;
        image_finished   <= e_fin;
      end else if (!complete) begin
        expecting_header <= e_hdr;
        packet_is_run    <= e_run;
        pixels_left      <= e_left;
        byte_position    <= e_bp + 2'd1;
        pixel_assembly   <= asm_new;
        pixels_done      <= e_done;
        image_finished   <= e_fin;
      end else begin
        packet_is_run  <= e_run;
        byte_position  <= '0;
        pixel_assembly <= '0;
        pixels_done    <= e_done + {{(IMG_W-LEFT_W){1'b0}}, n};
        image_finished <= fin_new;
        if (e_run) begin
          pixels_left      <= '0;
          expecting_header <= 1'b1;
        end else begin
          pixels_left      <= left_dec;
          expecting_header <= (left_dec == '0);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      emit_left <= '0;
    end else if (cmd.take && produce) begin
      out_valid <= 1'b1;
      emit_left <= first_left;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
      emit_left <= step_left;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && produce) begin
      run_pix        <= asm_new;
      run_fin        <= fin_new;
      pixel_first    <= asm_new;
      pixel_second   <= (first_cnt == LEFT_W'(2)) ? asm_new : '0;
      pixel_count    <= first_cnt[1:0];
      last_of_packet <= (first_left == '0);
      last_of_image  <= (first_left == '0) && fin_new;
    end else if (cmd.emit) begin
      pixel_first    <= run_pix;
      pixel_second   <= (step_cnt == LEFT_W'(2)) ? run_pix : '0;
      pixel_count    <= step_cnt[1:0];
      last_of_packet <= (step_left == '0);
      last_of_image  <= (step_left == '0) && run_fin;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/trd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module trd_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      in_ready,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [trd_pkg::PIX_W-1:0] pixel_first,
  input wire logic [trd_pkg::PIX_W-1:0] pixel_second,
  input wire logic [1:0]                pixel_count,
  input wire logic                      last_of_packet,
  input wire logic                      last_of_image
);
  import trd_pkg::*;

  // stalled request holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_first) && $stable(pixel_second)
      && $stable(pixel_count) && $stable(last_of_packet) && $stable(last_of_image))
    else $error("output request changed while stalled");

  // input taken only when the output register can move
  a_in_gated: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid || out_ready)
    else $error("input ready while output register blocked");

  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pixel_count == 2'd1) || (pixel_count == 2'd2))
    else $error("bad pixel count");

  a_second: assert property (@(posedge clk) disable iff (rst)
    out_valid && pixel_count == 2'd1 |-> pixel_second == '0)
    else $error("second pixel not zero on single result");

  a_image_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_image |-> last_of_packet)
    else $error("image end without packet end");

endmodule

bind tga_rle_decoder trd_checker u_trd_checker (.*);

`default_nettype wire

// ===== verif/trd_pixel_checker.sv =====
`timescale 1ns / 1ps

module trd_pixel_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [7:0]                data_byte,
  input  logic                      frame_start,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic [trd_pkg::IMG_W-1:0] cfg_data,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [trd_pkg::PIX_W-1:0] pixel_first,
  input  logic [trd_pkg::PIX_W-1:0] pixel_second,
  input  logic [1:0]                pixel_count,
  input  logic                      last_of_packet,
  input  logic                      last_of_image,
  output int                        mismatches,
  output int                        outstanding
);
  import trd_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] first;
    logic [PIX_W-1:0] second;
    logic [1:0]       cnt;
    logic             lop;
    logic             loi;
  } pixel_result_t;

  pixel_result_t expected_pixels[$];
  pixel_result_t want;

  logic [PB_W-1:0]  pb_reg;
  logic [IMG_W-1:0] img_size;

  logic             want_header;
  logic             run_pkt;
  logic [7:0]       left;
  logic [1:0]       pos;
  logic [31:0]      asm_pix;
  logic [IMG_W-1:0] done_cnt;
  logic             img_done;

  task automatic clear_decoder();
    want_header = 1'b1;
    run_pkt     = 1'b0;
    left        = '0;
    pos         = '0;
    asm_pix     = '0;
    done_cnt    = '0;
    img_done    = 1'b0;
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("%0t: %s got %0h, want %0h", $time, field, got, exp_val);
    mismatches++;
  endtask

  // work out the results one stream byte causes
  task automatic decode_byte(input logic [7:0] b, input logic fs);
    int unsigned eff;
    logic [PIX_W-1:0] pix;
    longint unsigned rem;
    longint unsigned n;
    longint unsigned k;
    pixel_result_t r;
    if (fs) clear_decoder();
    if (img_done || done_cnt >= img_size) begin
      img_done = 1'b1;
      return;
    end
    if (want_header) begin
      run_pkt     = b[HDR_RUN_BIT];
      left        = {1'b0, b[6:0] & HDR_COUNT_MASK} + 8'd1;
      pos         = '0;
      asm_pix     = '0;
      want_header = 1'b0;
      return;
    end
    asm_pix = asm_pix | (32'(b) << (8 * pos));
    eff = (pb_reg == '0) ? 1 : int'(pb_reg);
    if (eff > MAX_PIXEL_BYTES) eff = MAX_PIXEL_BYTES;
    if (int'(pos) + 1 < int'(eff)) begin
      pos = pos + 2'd1;
      return;
    end
    pix     = asm_pix[PIX_W-1:0];
    pos     = '0;
    asm_pix = '0;
    rem     = 64'(img_size) - 64'(done_cnt);
    if (run_pkt) begin
      n = 64'(left);
      if (n > rem) n = rem;
      left = '0;
    end else begin
      n = (rem > 0 && left > 0) ? 1 : 0;
      if (left > 0) left = left - 8'd1;
    end
    done_cnt = done_cnt + 32'(n);
    if (left == '0) want_header = 1'b1;
    if (done_cnt >= img_size) img_done = 1'b1;
    for (k = 0; k < n; k += 2) begin
      r.first  = pix;
      r.cnt    = (n - k >= 2) ? 2'd2 : 2'd1;
      r.second = (r.cnt == 2'd2) ? pix : '0;
      r.lop    = (k + 2 >= n);
      r.loi    = (k + 2 >= n) && img_done;
      expected_pixels.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pb_reg   = PIXEL_BYTES_RST;
      img_size = IMAGE_PIXELS_RST;
      clear_decoder();
      expected_pixels.delete();
      mismatches = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("unexpected result, pixel_first", 32'(pixel_first), 0);
        end else begin
          want = expected_pixels.pop_front();
          if (pixel_first !== want.first)
            report_mismatch("pixel_first", 32'(pixel_first), 32'(want.first));
          if (pixel_second !== want.second)
            report_mismatch("pixel_second", 32'(pixel_second), 32'(want.second));
          if (pixel_count !== want.cnt)
            report_mismatch("pixel_count", 32'(pixel_count), 32'(want.cnt));
          if (last_of_packet !== want.lop)
            report_mismatch("last_of_packet", 32'(last_of_packet), 32'(want.lop));
          if (last_of_image !== want.loi)
            report_mismatch("last_of_image", 32'(last_of_image), 32'(want.loi));
        end
      end
      if (in_valid && in_ready) decode_byte(data_byte, frame_start);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_PIXEL_BYTES) pb_reg = cfg_data[PB_W-1:0];
        else img_size = cfg_data;
      end
    end
    outstanding = expected_pixels.size();
  end

endmodule

// ===== verif/tb_tga_rle_decoder.sv =====
`timescale 1ns / 1ps

module tb_tga_rle_decoder;
  import trd_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [7:0]        data_byte = '0;
  logic              frame_start = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_index = REG_PIXEL_BYTES;
  logic [IMG_W-1:0]  cfg_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [PIX_W-1:0]  pixel_first;
  logic [PIX_W-1:0]  pixel_second;
  logic [1:0]        pixel_count;
  logic              last_of_packet;
  logic              last_of_image;

  int mismatches;
  int outstanding;
  int cycle_cnt = 0;
  int stim_items = 0;
  bit in_idle = 1'b1;
  bit out_idle = 1'b1;
  bit hold_req = 1'b0;
  bit hold_ack = 1'b0;

  tga_rle_decoder u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .frame_start   (frame_start),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pixel_first   (pixel_first),
    .pixel_second  (pixel_second),
    .pixel_count   (pixel_count),
    .last_of_packet(last_of_packet),
    .last_of_image (last_of_image)
  );

  trd_pixel_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .frame_start   (frame_start),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pixel_first   (pixel_first),
    .pixel_second  (pixel_second),
    .pixel_count   (pixel_count),
    .last_of_packet(last_of_packet),
    .last_of_image (last_of_image),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // output side: random stalls plus one long hold-off
  initial begin
    @(negedge clk);
    forever begin
      if (hold_req && !hold_ack) begin
        out_ready = 1'b0;
        repeat (250) @(negedge clk);
        hold_ack = 1'b1;
      end else if (out_idle && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
      end else begin
        out_ready = 1'b1;
        @(negedge clk);
      end
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b, input logic fs);
    if (in_idle && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid    = 1'b1;
    data_byte   = b;
    frame_start = fs;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [IMG_W-1:0] val);
    in_valid  = 1'b0;
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    // hold the request until the block takes it
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic send_image(input logic [1:0] pb_sel, input logic [IMG_W-1:0] img_len);
    int unsigned bpp;
    int unsigned done_px;
    int unsigned budget;
    int unsigned used;
    int unsigned cnt;
    int unsigned nbytes;
    logic run_hdr;
    logic fs;
    bpp     = (pb_sel == 2'd0) ? 1 : int'(pb_sel);
    done_px = 0;
    used    = 0;
    fs      = 1'b1;
    budget  = $urandom_range(10, 60);
    while (done_px < img_len && used < budget) begin
      if (stim_items + used > 240) begin
        in_idle  = 1'b0;
        out_idle = 1'b0;
      end
      if ($urandom_range(0, 19) == 0) begin
        send_byte(8'($urandom), 1'b0);
        used++;
      end else begin
        run_hdr = 1'($urandom_range(0, 1));
        cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 7);
        if (!run_hdr) cnt = cnt % 16;
        // restart the frame part way through
        if (!fs && $urandom_range(0, 29) == 0) begin
          fs      = 1'b1;
          done_px = 0;
        end
        send_byte({run_hdr, 7'(cnt)}, fs);
        fs = 1'b0;
        nbytes = run_hdr ? bpp : (cnt + 1) * bpp;
        if (!run_hdr && $urandom_range(0, 19) == 0) nbytes = $urandom_range(0, nbytes - 1);
        repeat (nbytes) send_byte(8'($urandom), 1'b0);
        used    += nbytes + 1;
        done_px += cnt + 1;
      end
    end
    stim_items += used;
    if (done_px >= img_len) send_byte(8'($urandom), done_px == 0);
  endtask

  initial begin
    logic [1:0]       pb_cfg;
    logic [IMG_W-1:0] img_cfg;
    int               img_no;

    repeat (11) @(negedge clk);
    rst = 1'b0;

    // a long run cut short by the image size, then a byte after the end
    write_reg(REG_PIXEL_BYTES, 32'd1);
    write_reg(REG_IMAGE_PIXELS, 32'd20);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hAA, 1'b0);
    wait_idle();

    // pixel size zero behaves as one byte
    write_reg(REG_PIXEL_BYTES, 32'd0);
    write_reg(REG_IMAGE_PIXELS, 32'hFFFF_FFFF);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h81, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    wait_idle();

    // two-byte pixels, then the size drops part way through a pixel
    write_reg(REG_PIXEL_BYTES, 32'd2);
    send_byte(8'h01, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'h3C, 1'b0);
    send_byte(8'h96, 1'b0);
    send_byte(8'h69, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'h12, 1'b0);
    wait_idle();
    write_reg(REG_PIXEL_BYTES, 32'd1);
    send_byte(8'h34, 1'b0);
    wait_idle();

    // image size lowered below the pixels already produced
    write_reg(REG_PIXEL_BYTES, 32'd3);
    write_reg(REG_IMAGE_PIXELS, 32'd3);
    send_byte(8'h80, 1'b0);
    wait_idle();

    // empty image
    write_reg(REG_IMAGE_PIXELS, 32'd0);
    send_byte(8'h80, 1'b1);
    wait_idle();

    write_reg(REG_IMAGE_PIXELS, 32'hFFFE_0001);
    send_byte(8'h80, 1'b1);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    wait_idle();

    img_no = 0;
    while (stim_items < 290) begin
      img_no++;
      pb_cfg = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 9))
        0:       img_cfg = 32'hFFFF_FFFF;
        1:       img_cfg = 32'd0;
        2:       img_cfg = 32'd1;
        default: img_cfg = $urandom_range(2, 80);
      endcase
      if (img_no == 2) img_cfg = 32'd500;
      wait_idle();
      write_reg(REG_PIXEL_BYTES, 32'(pb_cfg));
      write_reg(REG_IMAGE_PIXELS, img_cfg);
      if (img_no == 2) hold_req = 1'b1;
      send_image(pb_cfg, img_cfg);
    end
    in_valid = 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
